[hdl/quaternion_to_euler_angles_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the quaternion to Euler angle core
// Short forms for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_ANGLES_CORE_MACROS_SVH
`define QUATERNION_TO_EULER_ANGLES_CORE_MACROS_SVH

// The consequent must hold whenever the antecedent holds, outside reset.
`define Q2E_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// The condition must never be seen outside reset.
`define Q2E_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

[hdl/q2e_pkg.sv]
// ----------------------------------------------------------------------------
// Quaternion to Euler angle package
// Formats, pipeline record types and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package q2e_pkg;

  // Default configuration.
  localparam int DEF_QUAT_FRAC_BITS  = 14;
  localparam int DEF_ANGLE_FRAC_BITS = 13;
  localparam int DEF_CORDIC_STEPS    = 16;

  // Working formats: CORDIC operands carry 28 fraction bits, angles 30.
  localparam int WORK_FRAC = 28;
  localparam int ACC_FRAC  = 30;
  localparam int WORK_W    = WORK_FRAC + 3;  // terms in [-4.0, 4.0)
  localparam int SIN_W     = WORK_FRAC + 2;  // pitch sine in [-1.0, 1.0]
  localparam int CW        = WORK_FRAC + 6;  // CORDIC x/y with gain headroom
  localparam int ZW        = ACC_FRAC + 5;   // angle accumulator
  localparam int RAD_W     = 2 * WORK_FRAC + 2;
  localparam int ROOT_W    = WORK_FRAC + 1;
  localparam int REM_W     = ROOT_W + 3;
  localparam int ISQ_STEPS = RAD_W / 2;

  localparam logic signed [ZW-1:0] PI_Q30      = ZW'(64'sd3373259426);
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = ZW'(64'sd1686629713);

  typedef logic signed [WORK_W-1:0] work_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } pos_t;

  // Trigonometric terms of one pose in working format.
  typedef struct packed {
    pos_t                     pos;
    work_t                    sr;
    work_t                    cr;
    work_t                    sy;
    work_t                    cy;
    logic signed [SIN_W-1:0]  sp;
    logic                     sat_p;
    logic                     sat_n;
  } term_t;

  // One CORDIC vector with its angle accumulator.
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cvec_t;

  // Record that travels down the CORDIC stages.
  typedef struct packed {
    pos_t  pos;
    cvec_t roll;
    cvec_t pitch;
    cvec_t yaw;
    logic  sat_p;
    logic  sat_n;
  } cstage_t;

  // atan(2^-i) in Q2.30.
  function automatic logic signed [ZW-1:0] atan_tab(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    unique case (i)
      5'd0:    v = ZW'(64'sd843314857);
      5'd1:    v = ZW'(64'sd497837829);
      5'd2:    v = ZW'(64'sd263043837);
      5'd3:    v = ZW'(64'sd133525159);
      5'd4:    v = ZW'(64'sd67021687);
      5'd5:    v = ZW'(64'sd33543516);
      5'd6:    v = ZW'(64'sd16775851);
      5'd7:    v = ZW'(64'sd8388437);
      5'd8:    v = ZW'(64'sd4194283);
      5'd9:    v = ZW'(64'sd2097149);
      5'd31:   v = ZW'(64'sd1);
      default: v = ZW'(64'sd1 <<< (5'd30 - i));
    endcase
    return v;
  endfunction

endpackage

[hdl/quaternion_to_euler_angles_core.sv]
// ----------------------------------------------------------------------------
// Quaternion to Euler angle core
// Pipelined roll, pitch and yaw from a unit quaternion, position passed along.
// ----------------------------------------------------------------------------
// Usage:
// A pose transfer takes place at each rising edge with start high and busy
// low; busy is high only while reset is held, so a new pose may be offered in
// every cycle after reset.
// Inputs are the quaternion (signed, QUAT_FRAC_BITS fraction) and a Q16.16
// position. Each pose produces one result, shown for one cycle with out_valid
// high: the position unchanged and roll, pitch and yaw in radians with
// ANGLE_FRAC_BITS fraction bits.
// The pipeline has one multiply stage, one term stage, one square stage, 29
// square root stages for the pitch cosine, one quadrant stage, one stage per
// CORDIC step and the output stage.
// Throughput is one pose per cycle; the three CORDICs run side by side.
// Reset clears all valid bits; poses in flight are dropped.
// The receiver cannot stall, so results leave in order with no buffering.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_core #(
  parameter int QUAT_FRAC_BITS  = q2e_pkg::DEF_QUAT_FRAC_BITS,
  parameter int ANGLE_FRAC_BITS = q2e_pkg::DEF_ANGLE_FRAC_BITS,
  parameter int CORDIC_STEPS    = q2e_pkg::DEF_CORDIC_STEPS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_quat_w,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  output logic               out_valid,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [15:0] out_roll_angle,
  output logic signed [14:0] out_pitch_angle,
  output logic signed [15:0] out_yaw_angle
);
  import q2e_pkg::*;

  localparam int PROD_W = 32;
  localparam int SUMW   = (2 * QUAT_FRAC_BITS + 4 > 36) ? 2 * QUAT_FRAC_BITS + 4 : 36;
  localparam int DSH    = 2 * QUAT_FRAC_BITS - WORK_FRAC;
  localparam int RSH    = (DSH > 0) ? DSH : 0;
  localparam int LSH    = (DSH < 0) ? -DSH : 0;
  localparam int QSH    = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam int LAT    = 5 + ISQ_STEPS + CORDIC_STEPS;

  localparam logic signed [SUMW-1:0] ONE = SUMW'(1) <<< (2 * QUAT_FRAC_BITS);
  localparam logic signed [SUMW-1:0] LIM = SUMW'(1) <<< (2 * QUAT_FRAC_BITS + 2);
  localparam work_t WONE = WORK_W'(1) <<< WORK_FRAC;

  // Saturate a term to [-4.0, 4.0 - 1 lsb].
  function automatic logic signed [SUMW-1:0] sat_term(input logic signed [SUMW-1:0] v);
    logic signed [SUMW-1:0] r;
    if (v < -LIM) r = -LIM;
    else if (v > LIM - SUMW'(1)) r = LIM - SUMW'(1);
    else r = v;
    return r;
  endfunction

  // Bring a term to 28 fraction bits, floor on a right shift.
  function automatic work_t to_work(input logic signed [SUMW-1:0] v);
    return WORK_W'((v <<< LSH) >>> RSH);
  endfunction

  function automatic logic signed [SUMW-1:0] sx(input logic signed [PROD_W-1:0] p);
    return SUMW'(p);
  endfunction

  // Quadrant fold: a vector in the left half plane is negated and starts at +-pi.
  function automatic cvec_t cpre(input logic signed [CW-1:0] y, input logic signed [CW-1:0] x);
    cvec_t r;
    if (x < 0) begin
      r.x = -x;
      r.y = -y;
      r.z = (y >= 0) ? PI_Q30 : -PI_Q30;
    end else begin
      r.x = x;
      r.y = y;
      r.z = '0;
    end
    return r;
  endfunction

  // One vectoring step; a zero y leaves the vector alone.
  function automatic cvec_t cstep(input cvec_t a, input logic [4:0] i);
    cvec_t r;
    r = a;
    if (a.y > 0) begin
      r.x = a.x + (a.y >>> i);
      r.y = a.y - (a.x >>> i);
      r.z = a.z + atan_tab(i);
    end else if (a.y < 0) begin
      r.x = a.x - (a.y >>> i);
      r.y = a.y + (a.x >>> i);
      r.z = a.z - atan_tab(i);
    end
    return r;
  endfunction

  function automatic logic signed [ZW-1:0] clampz(input logic signed [ZW-1:0] z,
                                                   input logic signed [ZW-1:0] lim);
    logic signed [ZW-1:0] r;
    if (z < -lim) r = -lim;
    else if (z > lim) r = lim;
    else r = z;
    return r;
  endfunction

  // Round half up to the output fraction, then saturate to 16 bits.
  function automatic logic signed [15:0] quant16(input logic signed [ZW-1:0] z);
    logic signed [ZW:0] r;
    logic signed [ZW:0] lim;
    lim = (ZW + 1)'(1) <<< 15;
    r   = ((ZW + 1)'(z) + ((ZW + 1)'(1) <<< (QSH - 1))) >>> QSH;
    if (r < -lim) r = -lim;
    else if (r > lim - (ZW + 1)'(1)) r = lim - (ZW + 1)'(1);
    return r[15:0];
  endfunction

  function automatic logic signed [14:0] quant15(input logic signed [ZW-1:0] z);
    logic signed [ZW:0] r;
    logic signed [ZW:0] lim;
    lim = (ZW + 1)'(1) <<< 14;
    r   = ((ZW + 1)'(z) + ((ZW + 1)'(1) <<< (QSH - 1))) >>> QSH;
    if (r < -lim) r = -lim;
    else if (r > lim - (ZW + 1)'(1)) r = lim - (ZW + 1)'(1);
    return r[14:0];
  endfunction

  logic [LAT-1:0] vld_r;

  // Valid bits travel with the data; nothing ever stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], start};
    end
  end

  // No transfer is taken while reset is held.
  assign busy      = ~rst_n;
  assign out_valid = vld_r[LAT-1];

  // Stage 1: quaternion products.
  logic signed [PROD_W-1:0] wx_r, yz_r, xx_r, yy_r, wy_r, zx_r, wz_r, xy_r, zz_r;
  pos_t pos1_r;

  always_ff @(posedge clk) begin
    wx_r   <= in_quat_w * in_quat_x;
    yz_r   <= in_quat_y * in_quat_z;
    xx_r   <= in_quat_x * in_quat_x;
    yy_r   <= in_quat_y * in_quat_y;
    wy_r   <= in_quat_w * in_quat_y;
    zx_r   <= in_quat_z * in_quat_x;
    wz_r   <= in_quat_w * in_quat_z;
    xy_r   <= in_quat_x * in_quat_y;
    zz_r   <= in_quat_z * in_quat_z;
    pos1_r <= '{x: in_pos_x, y: in_pos_y, z: in_pos_z};
  end

  // Stage 2: saturated terms in working format and pitch saturation flags.
  term_t t2_nxt, t2_r;
  logic signed [SUMW-1:0] sp_sat;
  work_t sp_w;

  always_comb begin
    t2_nxt.pos = pos1_r;
    t2_nxt.sr  = to_work(sat_term((sx(wx_r) + sx(yz_r)) <<< 1));
    t2_nxt.cr  = to_work(sat_term(ONE - ((sx(xx_r) + sx(yy_r)) <<< 1)));
    t2_nxt.sy  = to_work(sat_term((sx(wz_r) + sx(xy_r)) <<< 1));
    t2_nxt.cy  = to_work(sat_term(ONE - ((sx(yy_r) + sx(zz_r)) <<< 1)));
    sp_sat       = sat_term((sx(wy_r) - sx(zx_r)) <<< 1);
    t2_nxt.sat_p = (sp_sat >= ONE);
    t2_nxt.sat_n = (sp_sat <= -ONE);
    sp_w = to_work(sp_sat);
    if (sp_w > WONE) sp_w = WONE;
    else if (sp_w < -WONE) sp_w = -WONE;
    t2_nxt.sp = SIN_W'(sp_w);
  end

  always_ff @(posedge clk) begin
    t2_r <= t2_nxt;
  end

  // Stage 3 and square root stages: pitch cosine = floor(sqrt(1 - s*s)).
  term_t                   qt_r   [0:ISQ_STEPS];
  logic [RAD_W-1:0]        rad_r  [0:ISQ_STEPS];
  logic [REM_W-1:0]        rem_r  [0:ISQ_STEPS];
  logic [ROOT_W-1:0]       root_r [0:ISQ_STEPS];

  always_ff @(posedge clk) begin
    qt_r[0]   <= t2_r;
    rad_r[0]  <= (RAD_W'(1) << (2 * WORK_FRAC)) - (RAD_W'(t2_r.sp) * RAD_W'(t2_r.sp));
    rem_r[0]  <= '0;
    root_r[0] <= '0;
  end

  for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_isq
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic [REM_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] root_nxt;

    // One result bit per stage, two radicand bits consumed.
    always_comb begin
      rem_sh = {rem_r[k][REM_W-3:0], rad_r[k][RAD_W-1-2*k -: 2]};
      trial  = REM_W'({root_r[k], 2'b01});
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[k][ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[k][ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      qt_r[k+1]   <= qt_r[k];
      rad_r[k+1]  <= rad_r[k];
      rem_r[k+1]  <= rem_nxt;
      root_r[k+1] <= root_nxt;
    end
  end

  // Quadrant stage feeding the three CORDICs.
  cstage_t cs_r [0:CORDIC_STEPS];

  always_ff @(posedge clk) begin
    cs_r[0].pos   <= qt_r[ISQ_STEPS].pos;
    cs_r[0].roll  <= cpre(CW'(qt_r[ISQ_STEPS].sr), CW'(qt_r[ISQ_STEPS].cr));
    cs_r[0].yaw   <= cpre(CW'(qt_r[ISQ_STEPS].sy), CW'(qt_r[ISQ_STEPS].cy));
    cs_r[0].pitch <= cpre(CW'(qt_r[ISQ_STEPS].sp), CW'({1'b0, root_r[ISQ_STEPS]}));
    cs_r[0].sat_p <= qt_r[ISQ_STEPS].sat_p;
    cs_r[0].sat_n <= qt_r[ISQ_STEPS].sat_n;
  end

  // CORDIC steps, one stage each.
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      cs_r[i+1].pos   <= cs_r[i].pos;
      cs_r[i+1].roll  <= cstep(cs_r[i].roll, 5'(i));
      cs_r[i+1].pitch <= cstep(cs_r[i].pitch, 5'(i));
      cs_r[i+1].yaw   <= cstep(cs_r[i].yaw, 5'(i));
      cs_r[i+1].sat_p <= cs_r[i].sat_p;
      cs_r[i+1].sat_n <= cs_r[i].sat_n;
    end
  end

  // Output stage: clamp, pick saturated pitch, round to the output format.
  logic signed [ZW-1:0] pitch_z;

  always_comb begin
    if (cs_r[CORDIC_STEPS].sat_p) pitch_z = HALF_PI_Q30;
    else if (cs_r[CORDIC_STEPS].sat_n) pitch_z = -HALF_PI_Q30;
    else pitch_z = clampz(cs_r[CORDIC_STEPS].pitch.z, HALF_PI_Q30);
  end

  always_ff @(posedge clk) begin
    out_pos_x       <= cs_r[CORDIC_STEPS].pos.x;
    out_pos_y       <= cs_r[CORDIC_STEPS].pos.y;
    out_pos_z       <= cs_r[CORDIC_STEPS].pos.z;
    out_roll_angle  <= quant16(clampz(cs_r[CORDIC_STEPS].roll.z, PI_Q30));
    out_yaw_angle   <= quant16(clampz(cs_r[CORDIC_STEPS].yaw.z, PI_Q30));
    out_pitch_angle <= quant15(pitch_z);
  end

endmodule

[hdl/q2e_checker.sv]
// ----------------------------------------------------------------------------
// Quaternion to Euler angle port checker
// Watches the core's ports for timing and range of the results.
// ----------------------------------------------------------------------------
`include "quaternion_to_euler_angles_core_macros.svh"

module q2e_checker #(
  parameter int CORDIC_STEPS = q2e_pkg::DEF_CORDIC_STEPS
) (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic signed [15:0] out_roll_angle,
  input logic signed [14:0] out_pitch_angle,
  input logic signed [15:0] out_yaw_angle
);
  import q2e_pkg::*;

  localparam int LAT = 5 + ISQ_STEPS + CORDIC_STEPS;
  localparam logic signed [14:0] PITCH_MAX = 15'sd12868;
  localparam logic signed [15:0] ANG_MAX   = 16'sd25736;

  // The pipeline never pushes back.
  `Q2E_ASSERT_NEVER(a_never_busy, busy)

  // A result appears only for a transfer in that has passed through the whole pipeline.
  `Q2E_ASSERT_IMPLY(a_latency, out_valid, $past(start, LAT))

  // Pitch stays within a quarter turn.
  `Q2E_ASSERT_IMPLY(a_pitch_range, out_valid, (out_pitch_angle <= PITCH_MAX) && (out_pitch_angle >= -PITCH_MAX))

  // Roll stays within a half turn.
  `Q2E_ASSERT_IMPLY(a_roll_range, out_valid, (out_roll_angle <= ANG_MAX) && (out_roll_angle >= -ANG_MAX))

  // Yaw stays within a half turn.
  `Q2E_ASSERT_IMPLY(a_yaw_range, out_valid, (out_yaw_angle <= ANG_MAX) && (out_yaw_angle >= -ANG_MAX))

endmodule

bind quaternion_to_euler_angles_core q2e_checker #(
  .CORDIC_STEPS(CORDIC_STEPS)
) u_q2e_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_roll_angle (out_roll_angle),
  .out_pitch_angle(out_pitch_angle),
  .out_yaw_angle  (out_yaw_angle)
);

[dv/tb_quaternion_to_euler_angles_core.sv]
// ----------------------------------------------------------------------------
// Testbench for the quaternion to Euler angle core
// Drives poses in random bursts, predicts roll, pitch and yaw with a local
// CORDIC model and checks every result strobe against the oldest expectation.
// ----------------------------------------------------------------------------
module tb_quaternion_to_euler_angles_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  WATCHDOG_LIMIT = 4000;
  localparam int  DRAIN_CYCLES   = 80;
  localparam int  RANDOM_POSES   = 1230;
  localparam longint ONE_Q28     = 64'sd1 << 28;
  localparam longint LIM_Q28     = 64'sd1 << 30;
  localparam longint PI_RAD      = 64'sd3373259426;
  localparam longint HALF_PI_RAD = 64'sd1686629713;

  typedef struct {
    logic signed [15:0] w, x, y, z;
    logic [31:0]        px, py, pz;
  } pose_t;

  typedef struct {
    logic [31:0]        px, py, pz;
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
  } angles_t;

  typedef struct {
    pose_t       pose;
    bit          typed;
    angles_t     angles;
  } row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [15:0] in_quat_w = '0, in_quat_x = '0, in_quat_y = '0, in_quat_z = '0;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic               out_valid;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [15:0] out_roll_angle, out_yaw_angle;
  logic signed [14:0] out_pitch_angle;

  angles_t expected_angles[$];
  longint  atan_q30[32];
  int      error_count = 0;
  int      idle_cycles = 0;

  quaternion_to_euler_angles_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_quat_w(in_quat_w), .in_quat_x(in_quat_x), .in_quat_y(in_quat_y),
    .in_quat_z(in_quat_z), .in_pos_x(in_pos_x), .in_pos_y(in_pos_y),
    .in_pos_z(in_pos_z), .out_valid(out_valid), .out_pos_x(out_pos_x),
    .out_pos_y(out_pos_y), .out_pos_z(out_pos_z), .out_roll_angle(out_roll_angle),
    .out_pitch_angle(out_pitch_angle), .out_yaw_angle(out_yaw_angle)
  );

  always #2 clk = ~clk;

  // Arctangent table: pi/4 first, then the Taylor series of atan(2^-i).
  initial begin
    longint sum;
    longint term;
    int     e;
    atan_q30[0] = 64'sd843314857;
    for (int i = 1; i < 32; i++) begin
      sum = 0;
      for (int k = 0; k < 32; k++) begin
        e = 62 - i * (2 * k + 1);
        if (e < 0) break;
        term = (64'sd1 << e) / (2 * k + 1);
        sum = (k & 1) ? sum - term : sum + term;
      end
      atan_q30[i] = longint'((unsigned'(sum) + 64'd2147483648) >> 32);
    end
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Vectoring CORDIC with a left half-plane pre-rotation.
  function automatic longint vector_angle(longint sn, longint cs);
    longint ang = 0;
    longint nx, ny;
    if (sn == 0 && cs == 0) return 0;
    if (cs < 0) begin
      ang = (sn >= 0) ? PI_RAD : -PI_RAD;
      cs = -cs;
      sn = -sn;
    end
    for (int i = 0; i < 16; i++) begin
      nx = cs;
      ny = sn;
      if (sn > 0) begin
        nx = cs + (sn >>> i);
        ny = sn - (cs >>> i);
        ang += atan_q30[i];
      end else if (sn < 0) begin
        nx = cs - (sn >>> i);
        ny = sn + (cs >>> i);
        ang -= atan_q30[i];
      end
      cs = nx;
      sn = ny;
    end
    return clamp(ang, -PI_RAD, PI_RAD);
  endfunction

  function automatic longint floor_sqrt(longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  // Round half up from 30 to 13 fraction bits and saturate to the field width.
  function automatic longint to_angle(longint v, int w);
    longint r = (v + (64'sd1 << 16)) >>> 17;
    longint m = 64'sd1 << (w - 1);
    return clamp(r, -m, m - 1);
  endfunction

  function automatic angles_t predict_angles(pose_t p);
    angles_t a;
    longint  w = p.w, x = p.x, y = p.y, z = p.z;
    longint  sr, cr, sp, sy, cy, pitch, c;
    sr = clamp(2 * (w * x + y * z), -LIM_Q28, LIM_Q28 - 1);
    cr = clamp(ONE_Q28 - 2 * (x * x + y * y), -LIM_Q28, LIM_Q28 - 1);
    sp = clamp(2 * (w * y - z * x), -LIM_Q28, LIM_Q28 - 1);
    sy = clamp(2 * (w * z + x * y), -LIM_Q28, LIM_Q28 - 1);
    cy = clamp(ONE_Q28 - 2 * (y * y + z * z), -LIM_Q28, LIM_Q28 - 1);
    if (sp >= ONE_Q28) begin
      pitch = HALF_PI_RAD;
    end else if (sp <= -ONE_Q28) begin
      pitch = -HALF_PI_RAD;
    end else begin
      c = floor_sqrt(longint'(unsigned'((64'sd1 << 56) - sp * sp)));
      pitch = clamp(vector_angle(sp, c), -HALF_PI_RAD, HALF_PI_RAD);
    end
    a.px = p.px;
    a.py = p.py;
    a.pz = p.pz;
    a.roll = 16'(to_angle(vector_angle(sr, cr), 16));
    a.pitch = 15'(to_angle(pitch, 15));
    a.yaw = 16'(to_angle(vector_angle(sy, cy), 16));
    return a;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch on %s: expected %0h, actual %0h", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  // Result monitor: each strobe is one transfer, compared with the oldest pose.
  always @(posedge clk) begin
    angles_t e;
    if (rst_n && out_valid) begin
      if (expected_angles.size() == 0) begin
        $display("%0t unexpected result transfer", $time);
        error_count++;
      end else begin
        e = expected_angles.pop_front();
        check_field("pos_x", e.px, out_pos_x);
        check_field("pos_y", e.py, out_pos_y);
        check_field("pos_z", e.pz, out_pos_z);
        check_field("roll", 32'(e.roll), 32'(out_roll_angle));
        check_field("pitch", 32'(e.pitch), 32'(out_pitch_angle));
        check_field("yaw", 32'(e.yaw), 32'(out_yaw_angle));
      end
    end
  end

  // Watchdog on cycles with neither an input nor a result transfer.
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog expired", $time);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  int burst_left = 0;

  // Offers one pose and waits for its transfer; gaps fall between bursts.
  task automatic send_pose(pose_t p, bit typed, angles_t a);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      if (start) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
    end
    burst_left--;
    in_quat_w <= p.w;
    in_quat_x <= p.x;
    in_quat_y <= p.y;
    in_quat_z <= p.z;
    in_pos_x <= p.px;
    in_pos_y <= p.py;
    in_pos_z <= p.pz;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    expected_angles.push_back(typed ? a : predict_angles(p));
  endtask

  function automatic pose_t make_pose(int w, int x, int y, int z);
    pose_t p;
    p.w = 16'(w); p.x = 16'(x); p.y = 16'(y); p.z = 16'(z);
    p.px = $urandom(); p.py = $urandom(); p.pz = $urandom();
    return p;
  endfunction

  function automatic angles_t typed_angles(pose_t p, int r, int pt, int yw);
    angles_t a;
    a.px = p.px; a.py = p.py; a.pz = p.pz;
    a.roll = 16'(r); a.pitch = 15'(pt); a.yaw = 16'(yw);
    return a;
  endfunction

  initial begin
    row_t    rows[$];
    row_t    r;
    pose_t   p;
    angles_t none;
    real     qa, qb, qc, qd, n;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed poses: identity, zero vector, pitch saturation both ways, extremes.
    r.typed = 1;
    r.pose = make_pose(16384, 0, 0, 0);
    r.angles = typed_angles(r.pose, 0, 0, 0);
    rows.push_back(r);
    r.pose = make_pose(0, 0, 0, 0);
    r.angles = typed_angles(r.pose, 0, 0, 0);
    rows.push_back(r);
    r.pose = make_pose(16384, 0, 16384, 0);
    r.angles = typed_angles(r.pose, 25736, 12868, 25736);
    rows.push_back(r);
    r.pose = make_pose(16384, 0, -16384, 0);
    r.angles = typed_angles(r.pose, 25736, -12868, 25736);
    rows.push_back(r);
    r.typed = 0;
    foreach (rows[i]) begin
      rows[i].pose.px = (i == 0) ? 32'h8000_0000 : (i == 1) ? 32'h7fff_ffff : rows[i].pose.px;
      rows[i].angles.px = rows[i].pose.px;
    end
    rows.push_back('{make_pose(0, 16384, 0, 0), 0, none});
    rows.push_back('{make_pose(0, 0, 16384, 0), 0, none});
    rows.push_back('{make_pose(0, 0, 0, 16384), 0, none});
    rows.push_back('{make_pose(0, 0, 0, -16384), 0, none});
    rows.push_back('{make_pose(-16384, -16384, -16384, -16384), 0, none});
    rows.push_back('{make_pose(16384, 16384, 16384, 16384), 0, none});
    rows.push_back('{make_pose(11585, 0, 11585, 0), 0, none});
    rows.push_back('{make_pose(11585, 0, -11585, 0), 0, none});
    rows.push_back('{make_pose(11585, 11585, 0, 0), 0, none});
    rows.push_back('{make_pose(0, -11585, 0, 11585), 0, none});
    rows.push_back('{make_pose(-32768, 32767, -32768, 32767), 0, none});
    rows.push_back('{make_pose(32767, -32768, 32767, -32768), 0, none});
    rows.push_back('{make_pose(0, 16384, 0, -1), 0, none});
    rows.push_back('{make_pose(8192, 8192, 8192, 8192), 0, none});
    rows.push_back('{make_pose(1, 0, 0, 0), 0, none});
    rows.push_back('{make_pose(-1, -1, -1, -1), 0, none});
    foreach (rows[i]) send_pose(rows[i].pose, rows[i].typed, rows[i].angles);

    // Random poses: mostly unit quaternions, some near gimbal lock, some raw noise.
    for (int i = 0; i < RANDOM_POSES; i++) begin
      case ($urandom_range(0, 9))
        0: begin
          p = make_pose(0, 0, 0, 0);
          p.w = 16'($urandom()); p.x = 16'($urandom());
          p.y = 16'($urandom()); p.z = 16'($urandom());
        end
        1: begin
          qa = 11585.0 + $urandom_range(0, 40) - 20.0;
          p = make_pose($rtoi(qa), $urandom_range(0, 60) - 30,
                        ($urandom_range(0, 1) ? 1 : -1) * $rtoi(qa),
                        $urandom_range(0, 60) - 30);
        end
        default: begin
          qa = ($urandom_range(0, 65536) - 32768.0) / 32768.0;
          qb = ($urandom_range(0, 65536) - 32768.0) / 32768.0;
          qc = ($urandom_range(0, 65536) - 32768.0) / 32768.0;
          qd = ($urandom_range(0, 65536) - 32768.0) / 32768.0;
          n = $sqrt(qa * qa + qb * qb + qc * qc + qd * qd);
          if (n < 1.0e-3) n = 1.0;
          p = make_pose($rtoi(qa / n * 16384.0), $rtoi(qb / n * 16384.0),
                        $rtoi(qc / n * 16384.0), $rtoi(qd / n * 16384.0));
        end
      endcase
      send_pose(p, 0, none);
    end
    start <= 1'b0;

    // Drain the pipeline, then allow a margin for stray strobes.
    while (expected_angles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
